[src/rti_pkg.sv]
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types, widths and defaults of the regression tree inference engine.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int NUM_NODES_DEF    = 256;
    localparam int NUM_FEATURES_DEF = 64;
    localparam int NUM_TASKS_DEF    = 4;

    localparam int OPC_W  = 2;
    localparam int TASK_W = 2;
    localparam int NODE_W = 8;
    localparam int FIDX_W = 6;
    localparam int VAL_W  = 32;

    typedef enum logic [OPC_W-1:0] {
        OP_WR_NODE  = 2'd0,
        OP_WR_FEAT  = 2'd1,
        OP_CLASSIFY = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NODE,
        ST_FEAT,
        ST_DONE
    } t_state;

    // Shared by all tasks
    typedef struct packed {
        logic [FIDX_W-1:0] split;
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
    } t_node_ent;

    // Per task and node
    typedef struct packed {
        logic                    leaf;
        logic signed [VAL_W-1:0] leaf_value;
        logic signed [VAL_W-1:0] thr;
    } t_task_ent;

    // Result of one move of the walk
    typedef struct packed {
        logic [NODE_W-1:0] nxt;
        logic              oob;
    } t_step;

endpackage

[src/rti_ram.sv]
// ----------------------------------------------------------------------------
// rti_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/rti_step.sv]
// ----------------------------------------------------------------------------
// rti_step
// Shared split unit: signed compare of feature against threshold, child
// select and child range check.
// ----------------------------------------------------------------------------
module rti_step #(
    parameter int NUM_NODES = rti_pkg::NUM_NODES_DEF
) (
    input  logic signed [rti_pkg::VAL_W-1:0]  i_fval,
    input  logic signed [rti_pkg::VAL_W-1:0]  i_thr,
    input  logic        [rti_pkg::NODE_W-1:0] i_left,
    input  logic        [rti_pkg::NODE_W-1:0] i_right,
    output rti_pkg::t_step                    o_step
);

    logic go_left;

    always_comb begin
        go_left      = (i_fval <= i_thr);
        o_step.nxt   = go_left ? i_left : i_right;
        o_step.oob   = (32'(o_step.nxt) >= 32'(NUM_NODES));
    end

endmodule

[src/regression_tree_inference.sv]
// ----------------------------------------------------------------------------
// regression_tree_inference
// Regression tree inference engine, one tree per task. Write items load node
// entries and features; a classify item walks the task's tree from node 0.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake           | Payload
// input   | in        | i_valid / o_ready   | i_opcode .. i_feature_value
// result  | out       | o_valid / i_ready   | o_prediction, o_leaf_node,
//         |           |                     | o_walk_error
//
// A classify item walks the tree in moves: each move is a node memory read
// followed by a feature memory read and the shared compare.
// After reset a clearing pass over all NUM_TASKS*NUM_NODES task entries
// zeroes the leaf flags; o_ready stays low meanwhile.
// A finished result waits in the output register while write items go on;
// a further classify holds its result until the register is free.
// ----------------------------------------------------------------------------
module regression_tree_inference #(
    parameter int NUM_NODES    = rti_pkg::NUM_NODES_DEF,
    parameter int NUM_FEATURES = rti_pkg::NUM_FEATURES_DEF,
    parameter int NUM_TASKS    = rti_pkg::NUM_TASKS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic        [rti_pkg::OPC_W-1:0]   i_opcode,
    input  logic        [rti_pkg::TASK_W-1:0]  i_task_req,
    input  logic        [rti_pkg::NODE_W-1:0]  i_node_index,
    input  logic        [rti_pkg::FIDX_W-1:0]  i_split_feature,
    input  logic        [rti_pkg::NODE_W-1:0]  i_left_child,
    input  logic        [rti_pkg::NODE_W-1:0]  i_right_child,
    input  logic                               i_is_leaf,
    input  logic signed [rti_pkg::VAL_W-1:0]   i_threshold,
    input  logic signed [rti_pkg::VAL_W-1:0]   i_leaf_value,
    input  logic        [rti_pkg::FIDX_W-1:0]  i_feature_index,
    input  logic signed [rti_pkg::VAL_W-1:0]   i_feature_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [rti_pkg::VAL_W-1:0]   o_prediction,
    output logic        [rti_pkg::NODE_W-1:0]  o_leaf_node,
    output logic                               o_walk_error
);

    localparam int NMD  = NUM_NODES;
    localparam int TMD  = NUM_TASKS * NUM_NODES;
    localparam int FMD  = NUM_TASKS * NUM_FEATURES;
    localparam int NMAW = (NMD > 1) ? $clog2(NMD) : 1;
    localparam int TMAW = (TMD > 1) ? $clog2(TMD) : 1;
    localparam int FMAW = (FMD > 1) ? $clog2(FMD) : 1;
    localparam int MW   = $clog2(NUM_NODES + 1);
    localparam int NEW  = $bits(rti_pkg::t_node_ent);
    localparam int TEW  = $bits(rti_pkg::t_task_ent);

    rti_pkg::t_state r_state, n_state;

    logic [TMAW-1:0]            r_clr, n_clr;
    logic [rti_pkg::TASK_W-1:0] r_task, n_task;
    logic [rti_pkg::NODE_W-1:0] r_node, n_node;
    logic [MW-1:0]              r_moves, n_moves;
    logic                       r_fok, n_fok;

    logic signed [rti_pkg::VAL_W-1:0] r_pend_pred, n_pend_pred;
    logic [rti_pkg::NODE_W-1:0]       r_pend_leaf, n_pend_leaf;
    logic                             r_pend_err, n_pend_err;

    logic                             r_out_valid, n_out_valid;
    logic signed [rti_pkg::VAL_W-1:0] r_pred, n_pred;
    logic [rti_pkg::NODE_W-1:0]       r_leaf, n_leaf;
    logic                             r_err, n_err;

    // memory ports
    logic                 nm_we, nm_re, tm_we, tm_re, fm_we, fm_re;
    logic [NMAW-1:0]      nm_waddr, nm_raddr;
    logic [TMAW-1:0]      tm_waddr, tm_raddr;
    logic [FMAW-1:0]      fm_waddr, fm_raddr;
    rti_pkg::t_node_ent   nm_wdata, nm_rd;
    rti_pkg::t_task_ent   tm_wdata, tm_rd;
    logic [rti_pkg::VAL_W-1:0] fm_wdata, fm_rd;
    logic [NEW-1:0]       nm_rdata;
    logic [TEW-1:0]       tm_rdata;

    logic                             task_ok;
    logic signed [rti_pkg::VAL_W-1:0] fval;
    rti_pkg::t_step                   step;

    assign nm_rd   = rti_pkg::t_node_ent'(nm_rdata);
    assign tm_rd   = rti_pkg::t_task_ent'(tm_rdata);
    assign task_ok = (32'(i_task_req) < 32'(NUM_TASKS));
    assign fval    = r_fok ? $signed(fm_rd) : '0;

    rti_ram #(.WIDTH(NEW), .DEPTH(NMD)) u_node_mem (
        .i_clk   (i_clk),
        .i_we    (nm_we),
        .i_waddr (nm_waddr),
        .i_wdata (nm_wdata),
        .i_re    (nm_re),
        .i_raddr (nm_raddr),
        .o_rdata (nm_rdata)
    );

    rti_ram #(.WIDTH(TEW), .DEPTH(TMD)) u_task_mem (
        .i_clk   (i_clk),
        .i_we    (tm_we),
        .i_waddr (tm_waddr),
        .i_wdata (tm_wdata),
        .i_re    (tm_re),
        .i_raddr (tm_raddr),
        .o_rdata (tm_rdata)
    );

    rti_ram #(.WIDTH(rti_pkg::VAL_W), .DEPTH(FMD)) u_feat_mem (
        .i_clk   (i_clk),
        .i_we    (fm_we),
        .i_waddr (fm_waddr),
        .i_wdata (fm_wdata),
        .i_re    (fm_re),
        .i_raddr (fm_raddr),
        .o_rdata (fm_rd)
    );

    rti_step #(.NUM_NODES(NUM_NODES)) u_step (
        .i_fval  (fval),
        .i_thr   (tm_rd.thr),
        .i_left  (nm_rd.left),
        .i_right (nm_rd.right),
        .o_step  (step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rti_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_task      <= n_task;
        r_node      <= n_node;
        r_moves     <= n_moves;
        r_fok       <= n_fok;
        r_pend_pred <= n_pend_pred;
        r_pend_leaf <= n_pend_leaf;
        r_pend_err  <= n_pend_err;
        r_pred      <= n_pred;
        r_leaf      <= n_leaf;
        r_err       <= n_err;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_task      = r_task;
        n_node      = r_node;
        n_moves     = r_moves;
        n_fok       = r_fok;
        n_pend_pred = r_pend_pred;
        n_pend_leaf = r_pend_leaf;
        n_pend_err  = r_pend_err;
        n_out_valid = r_out_valid && !i_ready;
        n_pred      = r_pred;
        n_leaf      = r_leaf;
        n_err       = r_err;

        o_ready  = 1'b0;
        nm_we    = 1'b0;
        nm_re    = 1'b0;
        tm_we    = 1'b0;
        tm_re    = 1'b0;
        fm_we    = 1'b0;
        fm_re    = 1'b0;
        nm_waddr = NMAW'(i_node_index);
        nm_wdata = '{split: i_split_feature, left: i_left_child, right: i_right_child};
        nm_raddr = NMAW'(r_node);
        tm_waddr = TMAW'(32'(i_task_req) * 32'(NUM_NODES) + 32'(i_node_index));
        tm_wdata = '{leaf: i_is_leaf, leaf_value: i_leaf_value, thr: i_threshold};
        tm_raddr = TMAW'(32'(r_task) * 32'(NUM_NODES) + 32'(r_node));
        fm_waddr = FMAW'(32'(i_task_req) * 32'(NUM_FEATURES) + 32'(i_feature_index));
        fm_wdata = i_feature_value;
        fm_raddr = FMAW'(32'(r_task) * 32'(NUM_FEATURES) + 32'(nm_rd.split));

        case (r_state)
            rti_pkg::ST_CLEAR: begin
                tm_we    = 1'b1;
                tm_waddr = r_clr;
                tm_wdata = '0;
                n_clr    = r_clr + 1'b1;
                if (r_clr == TMAW'(TMD - 1)) begin
                    n_state = rti_pkg::ST_IDLE;
                end
            end
            rti_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && task_ok) begin
                    case (i_opcode)
                        rti_pkg::OP_WR_NODE: begin
                            if (32'(i_node_index) < 32'(NUM_NODES)) begin
                                nm_we = 1'b1;
                                tm_we = 1'b1;
                            end
                        end
                        rti_pkg::OP_WR_FEAT: begin
                            fm_we = (32'(i_feature_index) < 32'(NUM_FEATURES));
                        end
                        rti_pkg::OP_CLASSIFY: begin
                            // root lookup
                            nm_re    = 1'b1;
                            tm_re    = 1'b1;
                            nm_raddr = '0;
                            tm_raddr = TMAW'(32'(i_task_req) * 32'(NUM_NODES));
                            n_task   = i_task_req;
                            n_node   = '0;
                            n_moves  = '0;
                            n_state  = rti_pkg::ST_NODE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rti_pkg::ST_NODE: begin
                if (tm_rd.leaf) begin
                    n_pend_pred = tm_rd.leaf_value;
                    n_pend_leaf = r_node;
                    n_pend_err  = 1'b0;
                    n_state     = rti_pkg::ST_DONE;
                end else if (r_moves == MW'(NUM_NODES)) begin
                    n_pend_pred = '0;
                    n_pend_leaf = '0;
                    n_pend_err  = 1'b1;
                    n_state     = rti_pkg::ST_DONE;
                end else begin
                    // out-of-range feature reads as zero
                    n_fok   = (32'(nm_rd.split) < 32'(NUM_FEATURES));
                    fm_re   = n_fok;
                    n_state = rti_pkg::ST_FEAT;
                end
            end
            rti_pkg::ST_FEAT: begin
                n_moves = r_moves + 1'b1;
                if (step.oob) begin
                    n_pend_pred = '0;
                    n_pend_leaf = step.nxt;
                    n_pend_err  = 1'b1;
                    n_state     = rti_pkg::ST_DONE;
                end else begin
                    n_node   = step.nxt;
                    nm_re    = 1'b1;
                    tm_re    = 1'b1;
                    nm_raddr = NMAW'(step.nxt);
                    tm_raddr = TMAW'(32'(r_task) * 32'(NUM_NODES) + 32'(step.nxt));
                    n_state  = rti_pkg::ST_NODE;
                end
            end
            rti_pkg::ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_pred      = r_pend_pred;
                    n_leaf      = r_pend_leaf;
                    n_err       = r_pend_err;
                    n_state     = rti_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rti_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_prediction = r_pred;
    assign o_leaf_node  = r_leaf;
    assign o_walk_error = r_err;

endmodule

[src/rti_checker.sv]
// ----------------------------------------------------------------------------
// rti_checker
// Port-level checks of the regression tree inference engine.
// ----------------------------------------------------------------------------
module rti_checker #(
    parameter int NUM_NODES = rti_pkg::NUM_NODES_DEF,
    parameter int NUM_TASKS = rti_pkg::NUM_TASKS_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_ready,
    input logic        [rti_pkg::OPC_W-1:0]   i_opcode,
    input logic        [rti_pkg::TASK_W-1:0]  i_task_req,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic signed [rti_pkg::VAL_W-1:0]   o_prediction,
    input logic        [rti_pkg::NODE_W-1:0]  o_leaf_node,
    input logic                               o_walk_error
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_prediction)
            && $stable(o_leaf_node) && $stable(o_walk_error))
        else $error("result changed while stalled");

    a_err_pred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_walk_error |-> o_prediction == '0)
        else $error("error result with nonzero prediction");

    // error leaf is either zero (walk too long) or an out-of-range child
    a_err_leaf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_walk_error |->
            o_leaf_node == '0 || 32'(o_leaf_node) >= 32'(NUM_NODES))
        else $error("error result with in-range leaf");

    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_opcode == rti_pkg::OP_CLASSIFY
            && 32'(i_task_req) < 32'(NUM_TASKS) |=> !o_ready)
        else $error("ready during a walk");

endmodule

bind regression_tree_inference rti_checker #(
    .NUM_NODES (NUM_NODES),
    .NUM_TASKS (NUM_TASKS)
) u_rti_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_opcode     (i_opcode),
    .i_task_req   (i_task_req),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_prediction (o_prediction),
    .o_leaf_node  (o_leaf_node),
    .o_walk_error (o_walk_error)
);
